[hdl/hotp_pkg.sv]
package hotp_pkg;

    localparam int CodeDigitsDef = 6;

    typedef struct packed {
        logic        action;
        logic [63:0] moving_value;
        logic [19:0] code;
    } t_in_item;

    typedef struct packed {
        logic        valid_res;
        logic [19:0] computed_code;
    } t_out_item;

    // job handed from front to back: factor already divided when action is set
    typedef struct packed {
        logic [63:0] factor;
        logic [19:0] code;
    } t_job;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOAD,
        BK_ROUND,
        BK_ADD,
        BK_NEXT,
        BK_TRUNC,
        BK_MOD,
        BK_DONE
    } t_back_state;

    localparam logic [1:0] RegKeyHigh  = 2'd0;
    localparam logic [1:0] RegKeyLow   = 2'd1;
    localparam logic [1:0] RegTimeStep = 2'd2;

    localparam logic [159:0] ShaInit =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

endpackage

[hdl/hotp_front.sv]
module hotp_front
    import hotp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_item,
    input  logic [15:0] i_time_step,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    t_front_state r_state, n_state;
    logic [63:0] r_quot, n_quot;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_div, n_div;
    logic [19:0] r_code, n_code;
    logic [6:0]  r_cnt, n_cnt;
    logic [16:0] w_trial;

    // one quotient bit a cycle, restoring division
    assign w_trial = {r_rem, r_quot[63]} - {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (i_push) begin
                    n_state = i_item.action ? FR_DIV : FR_PUSH;
                end
            end
            FR_DIV: begin
                if (r_cnt == 7'd63) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (i_job_ready) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        n_code = r_code;
        n_cnt  = r_cnt;
        case (r_state)
            FR_IDLE: begin
                n_quot = i_item.moving_value;
                n_code = i_item.code;
                n_rem  = '0;
                n_cnt  = '0;
                n_div  = (i_time_step == 16'd0) ? 16'd1 : i_time_step;
            end
            FR_DIV: begin
                n_cnt = r_cnt + 7'd1;
                if (!w_trial[16]) begin
                    n_rem  = w_trial[15:0];
                    n_quot = {r_quot[62:0], 1'b1};
                end else begin
                    n_rem  = {r_rem[14:0], r_quot[63]};
                    n_quot = {r_quot[62:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_code <= n_code;
        r_cnt  <= n_cnt;
    end

    assign o_full      = (r_state != FR_IDLE);
    assign o_job_valid = (r_state == FR_PUSH);
    assign o_job       = '{factor: r_quot, code: r_code};

endmodule

[hdl/hotp_job_fifo.sv]
module hotp_job_fifo
    import hotp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_rd,
    output t_job o_job
);

    // two-entry queue
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_rd && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[hdl/hotp_back.sv]
module hotp_back
    import hotp_pkg::*;
#(
    parameter int CODE_DIGITS = CodeDigitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_take,
    input  t_job        i_job,
    input  logic [15:0] i_key_high,
    input  logic [63:0] i_key_low,
    output logic        o_res_valid,
    input  logic        i_res_take,
    output t_out_item   o_res
);

    localparam logic [31:0] Modulus = 32'(10 ** CODE_DIGITS);
    // floor(2^32 / Modulus); quotient estimate is exact or one short
    localparam logic [31:0] Recip   = 32'((64'd1 << 32) / 64'(Modulus));

    t_back_state r_state, n_state;
    logic [159:0] r_h;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_w [16];
    logic [6:0]   r_rnd;
    logic [1:0]   r_blk;
    logic [159:0] r_inner;
    logic [63:0]  r_factor;
    logic [19:0]  r_code;
    logic [31:0]  r_bin;
    logic [31:0]  r_quo;
    logic [1:0]   r_mstep;
    t_out_item    r_res;

    logic [511:0] w_block;
    logic [79:0]  w_key;
    logic [31:0]  w_f, w_k, w_t, w_wnew, w_wi;
    logic [159:0] w_sum;
    logic [3:0]   w_off;
    logic [63:0]  w_prod;
    logic [31:0]  w_qm;
    logic [31:0]  w_fix;

    assign w_key = {i_key_high, i_key_low};

    // blocks: 0 inner key pad, 1 inner factor, 2 outer key pad, 3 outer digest
    always_comb begin
        case (r_blk)
            2'd0: w_block = {w_key ^ {10{8'h36}}, {54{8'h36}}};
            2'd1: w_block = {r_factor, 8'h80, 376'd0, 64'd576};
            2'd2: w_block = {w_key ^ {10{8'h5C}}, {54{8'h5C}}};
            default: w_block = {r_inner, 8'h80, 280'd0, 64'd672};
        endcase
    end

    assign w_wnew = rotl1(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]);
    assign w_wi   = r_w[0];

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = 32'h5A827999;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'h6ED9EBA1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = 32'h8F1BBCDC;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'hCA62C1D6;
        end
    end

    assign w_t   = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_wi;
    assign w_sum = {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                    r_h[63:32] + d_unused_guard(r_d), r_h[31:0] + r_e};
    assign w_off = r_h[3:0];
    // reduction by reciprocal multiply, then one conditional subtract
    assign w_prod = {32'd0, r_bin} * {32'd0, Recip};
    assign w_qm   = r_quo * Modulus;
    assign w_fix  = (r_bin >= Modulus) ? (r_bin - Modulus) : r_bin;

    function automatic logic [31:0] d_unused_guard(input logic [31:0] x);
        d_unused_guard = x;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (i_job_valid) n_state = BK_LOAD;
            BK_LOAD:  n_state = BK_ROUND;
            BK_ROUND: if (r_rnd == 7'd79) n_state = BK_ADD;
            BK_ADD:   n_state = (r_blk == 2'd3) ? BK_TRUNC : BK_NEXT;
            BK_NEXT:  n_state = BK_LOAD;
            BK_TRUNC: n_state = BK_MOD;
            BK_MOD:   if (r_mstep == 2'd2) n_state = BK_DONE;
            BK_DONE:  if (i_res_take) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    assign o_job_take  = (r_state == BK_IDLE) && i_job_valid;
    assign o_res_valid = (r_state == BK_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            BK_IDLE: begin
                r_factor <= i_job.factor;
                r_code   <= i_job.code;
                r_blk    <= 2'd0;
                r_h      <= ShaInit;
            end
            BK_LOAD: begin
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= w_block[511 - 32 * i -: 32];
                end
                {r_a, r_b, r_c, r_d, r_e} <= r_h;
                r_rnd <= '0;
            end
            BK_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= w_wnew;
                r_e <= r_d;
                r_d <= r_c;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a;
                r_a <= w_t;
                r_rnd <= r_rnd + 7'd1;
            end
            BK_ADD: begin
                r_h <= w_sum;
            end
            BK_NEXT: begin
                r_blk <= r_blk + 2'd1;
                if (r_blk == 2'd1) begin
                    r_inner <= r_h;
                    r_h     <= ShaInit;
                end
            end
            BK_TRUNC: begin
                // low 31 bits of the big-endian word at the offset byte
                r_bin   <= {1'b0, r_h[158 - 8 * w_off -: 31]};
                r_mstep <= '0;
            end
            BK_MOD: begin
                case (r_mstep)
                    2'd0: r_quo <= w_prod[63:32];
                    2'd1: r_bin <= r_bin - w_qm;
                    default: ;
                endcase
                r_mstep <= r_mstep + 2'd1;
            end
            default: ;
        endcase
        if (r_state == BK_MOD && r_mstep == 2'd2) begin
            r_res.computed_code <= w_fix[19:0];
            r_res.valid_res     <= (r_code == w_fix[19:0]);
        end
    end

endmodule

[hdl/hotp_out_buf.sv]
module hotp_out_buf
    import hotp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_take,
    input  t_out_item i_res,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_res
);

    logic      r_full;
    t_out_item r_res;

    assign o_take  = !r_full || i_pop;
    assign o_empty = !r_full;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_take) begin
            r_full <= i_valid;
        end
        if (o_take && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

[hdl/hotp_totp_code_checker.sv]
// hotp / totp one-time code checker, hmac-sha1 with dynamic truncation
// input channel: push/full queue of {action, moving_value, code}; action 1
//   divides unix time by time_step (zero acts as one) before hashing
// result channel: empty/pop queue of {valid_res, computed_code}, one per item
// config: apb writes, key_high at 0x0, key_low at 0x8, time_step at 0x10
// datapath: front runs a bit-serial 64-step restoring divider for a totp
//   divide and passes hotp items straight on; back runs four sha-1 blocks
//   with 3 block switches on one shared round unit, then truncation and
//   reciprocal-multiply reduction
// throughput: one item per back-end pass; the front can divide the next
//   item while the back hashes, via a two-entry job queue
// reset: synchronous, active low; key clears to zero, time_step to 30,
//   all queues empty
// stall: a result waits in the output register while pop is low; the back
//   and then the front hold, and full stays high until room frees up
module hotp_totp_code_checker
    import hotp_pkg::*;
#(
    parameter int CODE_DIGITS = CodeDigitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_item,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [15:0] r_key_high;
    logic [63:0] r_key_low;
    logic [15:0] r_time_step;
    logic [1:0]  w_reg;

    t_job      w_fjob, w_bjob;
    logic      w_fvalid, w_fready, w_qvalid, w_qtake;
    logic      w_rvalid, w_rtake;
    t_out_item w_res;

    // register index from byte address, 8 bytes per register
    assign w_reg  = paddr[4:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_time_step <= 16'd30;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                RegKeyHigh:  r_key_high  <= pwdata[15:0];
                RegKeyLow:   r_key_low   <= pwdata;
                RegTimeStep: r_time_step <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            RegKeyHigh:  prdata = {48'd0, r_key_high};
            RegKeyLow:   prdata = r_key_low;
            RegTimeStep: prdata = {48'd0, r_time_step};
            default:     prdata = '0;
        endcase
    end

    // front: accept and divide
    hotp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .i_time_step (r_time_step),
        .o_job_valid (w_fvalid),
        .i_job_ready (w_fready),
        .o_job       (w_fjob)
    );

    hotp_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_fvalid),
        .o_ready (w_fready),
        .i_job   (w_fjob),
        .o_valid (w_qvalid),
        .i_rd    (w_qtake),
        .o_job   (w_bjob)
    );

    // back: hmac, truncation, reduction
    hotp_back #(.CODE_DIGITS(CODE_DIGITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .o_job_take  (w_qtake),
        .i_job       (w_bjob),
        .i_key_high  (r_key_high),
        .i_key_low   (r_key_low),
        .o_res_valid (w_rvalid),
        .i_res_take  (w_rtake),
        .o_res       (w_res)
    );

    hotp_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rvalid),
        .o_take  (w_rtake),
        .i_res   (w_res),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (o_item)
    );

`ifndef SYNTHESIS
    // the front holds its job while the queue has no room for it
    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fvalid && !w_fready |=> w_fvalid)
        else $error("job lost at queue");

    // the back holds its result stable until the output register takes it
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rvalid && !w_rtake |=> w_rvalid && $stable(w_res))
        else $error("result dropped");

    // a computed code stays below the modulus, checked for up to six digits
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_item.computed_code < 20'(32'(10 ** CODE_DIGITS) & 32'hFFFFF)
            || CODE_DIGITS > 6)
        else $error("code out of range");
`endif

endmodule
